FILE: src/pcmpk_pkg.sv
// Package: shared types, register map and format constants of the PCM peak meter.
package pcmpk_pkg;

    // Configuration register indexes (byte address = 4 * index)
    localparam int unsigned REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_BYTES      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IS_SIGNED         = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BIG_ENDIAN        = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_QUIET_RUNS_NEEDED = 2'd3;

    // Register reset values
    localparam logic [2:0] RST_SAMPLE_BYTES      = 3'd2;
    localparam logic       RST_IS_SIGNED         = 1'b1;
    localparam logic       RST_BIG_ENDIAN        = 1'b0;
    localparam logic [7:0] RST_QUIET_RUNS_NEEDED = 8'd5;

    // Supported sample sizes in bytes
    localparam logic [2:0] SB_ONE  = 3'd1;
    localparam logic [2:0] SB_TWO  = 3'd2;
    localparam logic [2:0] SB_FOUR = 3'd4;

    // Full scale per format
    localparam logic [31:0] FS_S8  = 32'd127;
    localparam logic [31:0] FS_U8  = 32'd255;
    localparam logic [31:0] FS_S16 = 32'd32767;
    localparam logic [31:0] FS_U16 = 32'd65535;
    localparam logic [31:0] FS_S32 = 32'h7fff_ffff;
    localparam logic [31:0] FS_U32 = 32'hffff_ffff;

    // Quiet threshold: peak*100 < fs  <=>  peak < ceil(fs/100)
    localparam logic [31:0] QT_S8  = 32'((64'(FS_S8)  + 64'd99) / 64'd100);
    localparam logic [31:0] QT_U8  = 32'((64'(FS_U8)  + 64'd99) / 64'd100);
    localparam logic [31:0] QT_S16 = 32'((64'(FS_S16) + 64'd99) / 64'd100);
    localparam logic [31:0] QT_U16 = 32'((64'(FS_U16) + 64'd99) / 64'd100);
    localparam logic [31:0] QT_S32 = 32'((64'(FS_S32) + 64'd99) / 64'd100);
    localparam logic [31:0] QT_U32 = 32'((64'(FS_U32) + 64'd99) / 64'd100);

    localparam logic [7:0] QUIET_RUNS_MAX = 8'd255;

    typedef struct packed {
        logic [2:0] sample_bytes;
        logic       is_signed;
        logic       big_endian;
        logic [7:0] quiet_runs_needed;
    } cfg_t;

    typedef struct packed {
        logic [31:0] peak_magnitude;
        logic        buffer_quiet;
        logic        speech_ended;
    } result_t;

    // Full scale for the format; zero for unsupported sample sizes
    function automatic logic [31:0] full_scale(logic [2:0] sb, logic sgn);
        logic [31:0] fs;
        fs = 32'd0;
        if (sb == SB_ONE) begin
            fs = sgn ? FS_S8 : FS_U8;
        end else if (sb == SB_TWO) begin
            fs = sgn ? FS_S16 : FS_U16;
        end else if (sb == SB_FOUR) begin
            fs = sgn ? FS_S32 : FS_U32;
        end
        return fs;
    endfunction

    // Smallest peak that is not quiet for the format
    function automatic logic [31:0] quiet_thresh(logic [2:0] sb, logic sgn);
        logic [31:0] qt;
        qt = 32'd0;
        if (sb == SB_ONE) begin
            qt = sgn ? QT_S8 : QT_U8;
        end else if (sb == SB_TWO) begin
            qt = sgn ? QT_S16 : QT_U16;
        end else if (sb == SB_FOUR) begin
            qt = sgn ? QT_S32 : QT_U32;
        end
        return qt;
    endfunction

endpackage

FILE: src/pcmpk_ifs.sv
// Interfaces: valid/ready channels for PCM bytes in and level results out.
interface pcmpk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pcm_byte;
    logic       buffer_end;

    modport source (output valid, output pcm_byte, output buffer_end, input ready);
    modport sink   (input valid, input pcm_byte, input buffer_end, output ready);
endinterface

interface pcmpk_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] peak_magnitude;
    logic        buffer_quiet;
    logic        speech_ended;

    modport source (output valid, output peak_magnitude, output buffer_quiet,
                    output speech_ended, input ready);
    modport sink   (input valid, input peak_magnitude, input buffer_quiet,
                    input speech_ended, output ready);
endinterface

FILE: src/pcmpk_cfg.sv
// APB-style configuration register file of the PCM peak meter.
module pcmpk_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output pcmpk_pkg::cfg_t   cfg
);

    pcmpk_pkg::cfg_t cfg_reg;
    pcmpk_pkg::cfg_t cfg_next;
    logic [pcmpk_pkg::REG_IDX_W-1:0] idx;
    logic wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Decode the write transaction
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                pcmpk_pkg::REG_SAMPLE_BYTES:      cfg_next.sample_bytes      = pwdata[2:0];
                pcmpk_pkg::REG_IS_SIGNED:         cfg_next.is_signed         = pwdata[0];
                pcmpk_pkg::REG_BIG_ENDIAN:        cfg_next.big_endian        = pwdata[0];
                pcmpk_pkg::REG_QUIET_RUNS_NEEDED: cfg_next.quiet_runs_needed = pwdata[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.sample_bytes      <= pcmpk_pkg::RST_SAMPLE_BYTES;
            cfg_reg.is_signed         <= pcmpk_pkg::RST_IS_SIGNED;
            cfg_reg.big_endian        <= pcmpk_pkg::RST_BIG_ENDIAN;
            cfg_reg.quiet_runs_needed <= pcmpk_pkg::RST_QUIET_RUNS_NEEDED;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (idx)
            pcmpk_pkg::REG_SAMPLE_BYTES:      prdata = {29'd0, cfg_reg.sample_bytes};
            pcmpk_pkg::REG_IS_SIGNED:         prdata = {31'd0, cfg_reg.is_signed};
            pcmpk_pkg::REG_BIG_ENDIAN:        prdata = {31'd0, cfg_reg.big_endian};
            pcmpk_pkg::REG_QUIET_RUNS_NEEDED: prdata = {24'd0, cfg_reg.quiet_runs_needed};
        endcase
    end

endmodule

FILE: src/pcmpk_meter.sv
// Sample assembly, peak tracking and quiet-run logic of the PCM peak meter.
module pcmpk_meter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pcmpk_pkg::cfg_t      cfg,
    input  logic                 step,
    input  logic [7:0]           pcm_byte,
    input  logic                 buffer_end,
    output pcmpk_pkg::result_t   res
);

    logic [23:0] partial_reg, partial_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] peak_reg, peak_next;
    logic [7:0]  runs_reg, runs_next;

    logic [31:0] fs, qt, combined, mask, neg, mag_raw, mag, peak_upd, peak_out;
    logic        fs_ok, sign_bit, complete, quiet;

    assign fs    = pcmpk_pkg::full_scale(cfg.sample_bytes, cfg.is_signed);
    assign qt    = pcmpk_pkg::quiet_thresh(cfg.sample_bytes, cfg.is_signed);
    assign fs_ok = (fs != 32'd0);

    // Mask for the sample width
    always_comb
    begin
        if (cfg.sample_bytes == pcmpk_pkg::SB_ONE) begin
            mask = 32'h0000_00ff;
        end else if (cfg.sample_bytes == pcmpk_pkg::SB_TWO) begin
            mask = 32'h0000_ffff;
        end else begin
            mask = 32'hffff_ffff;
        end
    end

    // Merge the new byte into the held bytes
    always_comb
    begin
        if (cfg.big_endian) begin
            combined = {partial_reg, pcm_byte} & mask;
        end else begin
            combined = ({8'd0, partial_reg} | (32'(pcm_byte) << {pos_reg, 3'b000})) & mask;
        end
    end

    always_comb
    begin
        if (cfg.sample_bytes == pcmpk_pkg::SB_ONE) begin
            sign_bit = combined[7];
        end else if (cfg.sample_bytes == pcmpk_pkg::SB_TWO) begin
            sign_bit = combined[15];
        end else begin
            sign_bit = combined[31];
        end
    end

    assign complete = ({1'b0, pos_reg} + 3'd1) >= cfg.sample_bytes;

    // Magnitude, clamped to full scale (covers the most negative value)
    assign neg      = (~combined + 32'd1) & mask;
    assign mag_raw  = (cfg.is_signed && sign_bit) ? neg : combined;
    assign mag      = (mag_raw > fs) ? fs : mag_raw;
    assign peak_upd = (fs_ok && complete && (mag > peak_reg)) ? mag : peak_reg;

    // Buffer result
    assign peak_out = fs_ok ? ((peak_upd > fs) ? fs : peak_upd) : 32'd0;
    assign quiet    = !fs_ok || (peak_out < qt);

    always_comb
    begin
        if (quiet) begin
            runs_next = (runs_reg == pcmpk_pkg::QUIET_RUNS_MAX) ? runs_reg : runs_reg + 8'd1;
        end else begin
            runs_next = 8'd0;
        end
    end

    assign res.peak_magnitude = peak_out;
    assign res.buffer_quiet   = quiet;
    assign res.speech_ended   = (runs_next > cfg.quiet_runs_needed);

    // Next state: a buffer end clears the partial sample and peak
    always_comb
    begin
        partial_next = partial_reg;
        pos_next     = pos_reg;
        peak_next    = peak_reg;
        if (step) begin
            if (buffer_end) begin
                partial_next = 24'd0;
                pos_next     = 2'd0;
                peak_next    = 32'd0;
            end else if (!fs_ok || complete) begin
                partial_next = 24'd0;
                pos_next     = 2'd0;
                peak_next    = peak_upd;
            end else begin
                partial_next = combined[23:0];
                pos_next     = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            partial_reg <= 24'd0;
            pos_reg     <= 2'd0;
            peak_reg    <= 32'd0;
            runs_reg    <= 8'd0;
        end else begin
            partial_reg <= partial_next;
            pos_reg     <= pos_next;
            peak_reg    <= peak_next;
            if (step && buffer_end) begin
                runs_reg <= runs_next;
            end
        end
    end

endmodule

FILE: src/pcm_peak_level_silence_detector.sv
// Top level of the PCM peak meter: input stage, meter, result register, APB port.
//
//  channel    dir  payload                                      transfer
//  pcm_in     in   pcm_byte[7:0], buffer_end                    valid & ready
//  level_out  out  peak_magnitude[31:0], buffer_quiet, speech   valid & ready
//  apb        in   sample_bytes, is_signed, big_endian, needed  psel & penable & pwrite
//
// One byte is accepted per cycle unless the input stage stalls: the result register
// stalls it only when full with a last byte waiting. A byte is registered on
// acceptance and folded into the peak as it advances; a buffer's result is loaded
// once its last byte advances. Reset clears the partial sample, peak and quiet run.
module pcm_peak_level_silence_detector (
    input  logic           clk,
    input  logic           rst_n,
    pcmpk_in_if.sink       pcm_in,
    pcmpk_out_if.source    level_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    pcmpk_pkg::cfg_t    cfg;
    pcmpk_pkg::result_t res;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    logic       out_valid_reg, out_valid_next;
    pcmpk_pkg::result_t out_reg;
    logic       out_free, s1_adv, in_take, out_load;

    pcmpk_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcmpk_meter u_meter (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step       (s1_adv),
        .pcm_byte   (s1_byte_reg),
        .buffer_end (s1_end_reg),
        .res        (res)
    );

    // Handshake: advance the input stage unless a last byte meets a full result register
    assign out_free     = !out_valid_reg || level_out.ready;
    assign s1_adv       = s1_valid_reg && (!s1_end_reg || out_free);
    assign pcm_in.ready = !s1_valid_reg || s1_adv;
    assign in_take      = pcm_in.valid && pcm_in.ready;
    assign out_load     = s1_adv && s1_end_reg;

    assign s1_valid_next  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (level_out.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the accepted byte
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            s1_byte_reg <= pcm_in.pcm_byte;
            s1_end_reg  <= pcm_in.buffer_end;
        end
    end

    // Capture the buffer result
    always_ff @(posedge clk)
    begin
        if (out_load) begin
            out_reg <= res;
        end
    end

    assign level_out.valid          = out_valid_reg;
    assign level_out.peak_magnitude = out_reg.peak_magnitude;
    assign level_out.buffer_quiet   = out_reg.buffer_quiet;
    assign level_out.speech_ended   = out_reg.speech_ended;

endmodule

FILE: src/pcmpk_checker.sv
// Port checker of the PCM peak meter and its bind to the top level.
module pcmpk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] peak_magnitude,
    input logic        buffer_quiet,
    input logic        speech_ended,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(peak_magnitude)
            && $stable(buffer_quiet) && $stable(speech_ended))
        else $error("result changed while stalled");

    // A loud buffer always has a nonzero peak
    a_loud_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !buffer_quiet |-> peak_magnitude != 32'd0)
        else $error("loud buffer with zero peak");

    // End of speech only follows a quiet buffer
    a_speech_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && speech_ended |-> buffer_quiet)
        else $error("speech ended on a loud buffer");

    // Read back the quiet run limit after writing it
    a_limit_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[3:2] == pcmpk_pkg::REG_QUIET_RUNS_NEEDED
        |=> paddr[3:2] != pcmpk_pkg::REG_QUIET_RUNS_NEEDED
            || prdata[7:0] == $past(pwdata[7:0]))
        else $error("quiet run limit readback mismatch");

endmodule

bind pcm_peak_level_silence_detector pcmpk_checker u_pcmpk_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (level_out.valid),
    .out_ready      (level_out.ready),
    .peak_magnitude (level_out.peak_magnitude),
    .buffer_quiet   (level_out.buffer_quiet),
    .speech_ended   (level_out.speech_ended),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata)
);
